// ===== rtl/sptn_pkg.sv =====
// shared types, constants and micro-op table of the point-triangle distance unit
`default_nettype none

package sptn_pkg;

    localparam int FracBits       = 24;
    localparam int DigitBits      = 8;
    localparam int SquareBitsMin  = 44;
    localparam int DistBits       = 23;
    localparam int DistMax        = 4194303;
    localparam int PcBits         = 6;

    localparam logic [PcBits-1:0] PcDotB  = 6'd6;
    localparam logic [PcBits-1:0] PcDotC  = 6'd12;
    localparam logic [PcBits-1:0] PcDetC  = 6'd18;
    localparam logic [PcBits-1:0] PcDetB  = 6'd20;
    localparam logic [PcBits-1:0] PcDetA  = 6'd22;
    localparam logic [PcBits-1:0] PcBlend = 6'd24;
    localparam logic [PcBits-1:0] PcLast  = 6'd35;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_ISSUE  = 10'b0000000010,
        ST_MUL    = 10'b0000000100,
        ST_CHECK  = 10'b0000001000,
        ST_DIVGO  = 10'b0000010000,
        ST_DIV    = 10'b0000100000,
        ST_UPDATE = 10'b0001000000,
        ST_ROOT   = 10'b0010000000,
        ST_ROUND  = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    typedef enum logic [5:0] {
        O_AB0, O_AB1, O_AB2, O_AC0, O_AC1, O_AC2,
        O_AP0, O_AP1, O_AP2, O_BP0, O_BP1, O_BP2,
        O_CP0, O_CP1, O_CP2,
        O_D1, O_D2, O_D3, O_D4, O_D5, O_D6,
        O_T, O_S, O_E0, O_E1, O_E2, O_F0, O_F1, O_F2,
        O_OFF0, O_OFF1, O_OFF2, O_N0, O_N1, O_N2
    } opnd_t;

    typedef enum logic [1:0] {
        AM_LOAD, AM_ADD, AM_SUB, AM_BLEND
    } acc_mode_t;

    typedef enum logic [3:0] {
        DS_NONE, DS_D1, DS_D2, DS_D3, DS_D4, DS_D5, DS_D6,
        DS_VC, DS_VB, DS_VA, DS_Q0, DS_Q1, DS_Q2, DS_SQ, DS_ND
    } dest_t;

    typedef enum logic [2:0] {
        RG_A, RG_B, RG_C, RG_AB, RG_AC, RG_BC, RG_IN
    } region_t;

    typedef struct packed {
        opnd_t     a;
        opnd_t     b;
        acc_mode_t mode;
        dest_t     dest;
        logic      check;
    } uop_t;

    function automatic uop_t mk(opnd_t a, opnd_t b, acc_mode_t m, dest_t d, logic ck);
        uop_t u;
        u.a     = a;
        u.b     = b;
        u.mode  = m;
        u.dest  = d;
        u.check = ck;
        return u;
    endfunction

    // one multiply-accumulate per step; check marks a region test after it
    function automatic uop_t uop_at(logic [PcBits-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = mk(O_AB0, O_AP0, AM_LOAD, DS_NONE, 1'b0);
            6'd1:  u = mk(O_AB1, O_AP1, AM_ADD,  DS_NONE, 1'b0);
            6'd2:  u = mk(O_AB2, O_AP2, AM_ADD,  DS_D1,   1'b0);
            6'd3:  u = mk(O_AC0, O_AP0, AM_LOAD, DS_NONE, 1'b0);
            6'd4:  u = mk(O_AC1, O_AP1, AM_ADD,  DS_NONE, 1'b0);
            6'd5:  u = mk(O_AC2, O_AP2, AM_ADD,  DS_D2,   1'b1);
            6'd6:  u = mk(O_AB0, O_BP0, AM_LOAD, DS_NONE, 1'b0);
            6'd7:  u = mk(O_AB1, O_BP1, AM_ADD,  DS_NONE, 1'b0);
            6'd8:  u = mk(O_AB2, O_BP2, AM_ADD,  DS_D3,   1'b0);
            6'd9:  u = mk(O_AC0, O_BP0, AM_LOAD, DS_NONE, 1'b0);
            6'd10: u = mk(O_AC1, O_BP1, AM_ADD,  DS_NONE, 1'b0);
            6'd11: u = mk(O_AC2, O_BP2, AM_ADD,  DS_D4,   1'b1);
            6'd12: u = mk(O_AB0, O_CP0, AM_LOAD, DS_NONE, 1'b0);
            6'd13: u = mk(O_AB1, O_CP1, AM_ADD,  DS_NONE, 1'b0);
            6'd14: u = mk(O_AB2, O_CP2, AM_ADD,  DS_D5,   1'b0);
            6'd15: u = mk(O_AC0, O_CP0, AM_LOAD, DS_NONE, 1'b0);
            6'd16: u = mk(O_AC1, O_CP1, AM_ADD,  DS_NONE, 1'b0);
            6'd17: u = mk(O_AC2, O_CP2, AM_ADD,  DS_D6,   1'b1);
            6'd18: u = mk(O_D1,  O_D4,  AM_LOAD, DS_NONE, 1'b0);
            6'd19: u = mk(O_D3,  O_D2,  AM_SUB,  DS_VC,   1'b1);
            6'd20: u = mk(O_D5,  O_D2,  AM_LOAD, DS_NONE, 1'b0);
            6'd21: u = mk(O_D1,  O_D6,  AM_SUB,  DS_VB,   1'b1);
            6'd22: u = mk(O_D3,  O_D6,  AM_LOAD, DS_NONE, 1'b0);
            6'd23: u = mk(O_D5,  O_D4,  AM_SUB,  DS_VA,   1'b1);
            6'd24: u = mk(O_T,   O_E0,  AM_BLEND, DS_NONE, 1'b0);
            6'd25: u = mk(O_S,   O_F0,  AM_ADD,  DS_Q0,   1'b0);
            6'd26: u = mk(O_T,   O_E1,  AM_BLEND, DS_NONE, 1'b0);
            6'd27: u = mk(O_S,   O_F1,  AM_ADD,  DS_Q1,   1'b0);
            6'd28: u = mk(O_T,   O_E2,  AM_BLEND, DS_NONE, 1'b0);
            6'd29: u = mk(O_S,   O_F2,  AM_ADD,  DS_Q2,   1'b0);
            6'd30: u = mk(O_OFF0, O_OFF0, AM_LOAD, DS_NONE, 1'b0);
            6'd31: u = mk(O_OFF1, O_OFF1, AM_ADD,  DS_NONE, 1'b0);
            6'd32: u = mk(O_OFF2, O_OFF2, AM_ADD,  DS_SQ,   1'b0);
            6'd33: u = mk(O_N0,  O_OFF0, AM_LOAD, DS_NONE, 1'b0);
            6'd34: u = mk(O_N1,  O_OFF1, AM_ADD,  DS_NONE, 1'b0);
            6'd35: u = mk(O_N2,  O_OFF2, AM_ADD,  DS_ND,   1'b0);
            default: u = mk(O_AB0, O_AB0, AM_LOAD, DS_NONE, 1'b0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sptn_mul.sv =====
// iterative signed multiplier, one 8-bit digit of the multiplier per cycle
`default_nettype none

module sptn_mul #(
    parameter int DW = 46,
    parameter int WW = 92
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] op_a,
    input  wire logic signed [DW-1:0] op_b,
    output logic                      done,
    output logic signed [WW-1:0]      prod
);
    import sptn_pkg::*;

    localparam int NumDigits = (DW + DigitBits - 1) / DigitBits;
    localparam int CntBits   = (NumDigits > 1) ? $clog2(NumDigits) : 1;

    logic [WW-1:0]      mcand_reg;
    logic [DW-1:0]      mplier_reg;
    logic [WW-1:0]      acc_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CntBits-1:0] cnt_reg;
    logic [DW-1:0]      mag_a;
    logic [DW-1:0]      mag_b;

    assign mag_a = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
    assign mag_b = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntBits'(NumDigits - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= WW'(mag_a);
            mplier_reg <= mag_b;
            acc_reg    <= '0;
            neg_reg    <= op_a[DW-1] ^ op_b[DW-1];
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + mcand_reg * WW'(mplier_reg[DigitBits-1:0]);
            mcand_reg  <= mcand_reg << DigitBits;
            mplier_reg <= mplier_reg >> DigitBits;
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

`default_nettype wire

// ===== rtl/sptn_div.sv =====
// restoring divider giving a ratio num/den as an unsigned fraction clamped to [0, 1]
`default_nettype none

module sptn_div #(
    parameter int WW = 92
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [WW-1:0] num,
    input  wire logic signed [WW-1:0] den,
    output logic                      done,
    output logic [sptn_pkg::FracBits:0] quot
);
    import sptn_pkg::*;

    localparam int CntBits = $clog2(FracBits);

    logic [WW-1:0]       rem_reg;
    logic [WW-1:0]       den_reg;
    logic [FracBits:0]   quot_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [CntBits-1:0]  cnt_reg;
    logic [WW-1:0]       rem_shift;
    logic                fits;

    assign rem_shift = {rem_reg[WW-2:0], 1'b0};
    assign fits      = (rem_shift >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                // out-of-range ratios finish at once
                if (den <= 0 || num <= 0 || num >= den)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntBits'(FracBits - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            if (den <= 0 || num <= 0)
            begin
                quot_reg <= '0;
            end
            else if (num >= den)
            begin
                quot_reg <= (FracBits + 1)'(1) << FracBits;
            end
            else
            begin
                quot_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_shift - den_reg : rem_shift;
            quot_reg <= {quot_reg[FracBits-1:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/signed_point_triangle_nearest_unit.sv =====
// top level of the signed point-to-triangle nearest distance unit
`default_nettype none

// Each input beat carries a query point, a triangle (three vertices and a
// normal), its index and a first flag on s_tuser; s_tlast marks the final
// candidate of a query. The unit finds the closest point of the triangle
// with the vertex / edge / interior region tests, forms the squared
// distance, signs it from the normal, and keeps the strictly smallest one
// since the last first beat. After a beat with s_tlast it sends one result
// beat: the rounded signed distance (Q12.10, saturated), the index of the
// nearest triangle and a found flag on m_tuser. All products run through
// one shared multiplier that takes one 8-bit digit per cycle, and all ratios
// through one restoring divider at one quotient bit per cycle. A beat costs
// 18 to 36 multiplies (a vertex region ends the tests early), a test step
// after each region test, and up to two divides for edge and interior
// regions. A last beat adds the square root, one result bit per cycle,
// then a round step and an output step that loads the result. s_tready is
// low while a beat is in work; a finished result waits in the output
// register and does not hold off the next beat.
module signed_point_triangle_nearest_unit #(
    parameter int COORD_BITS = 20,
    parameter int INDEX_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // query_point, vertex_a, vertex_b, vertex_c, tri_normal, tri_index
    input  wire logic [((15*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic s_tuser,   // first
    input  wire logic s_tlast,   // last
    // signed_distance, closest_index
    output logic [((sptn_pkg::DistBits+INDEX_BITS+7)/8)*8-1:0] m_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic      m_tuser    // found
);
    import sptn_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int IW   = INDEX_BITS;
    localparam int VW   = CW + 1;
    localparam int DW   = 2 * CW + 6;
    localparam int WW   = 2 * DW;
    localparam int PW   = 3 * CW;
    localparam int SQW  = (2 * CW + 4 > SquareBitsMin) ? 2 * CW + 4 : SquareBitsMin;
    localparam int RT   = (SQW + 1) / 2;
    localparam int RW   = 2 * RT;
    localparam int RCB  = $clog2(RT);
    localparam int ODW  = ((DistBits + IW + 7) / 8) * 8;

    localparam logic signed [WW-1:0] HalfLsb = WW'(1) << (FracBits - 1);
    localparam logic signed [WW-1:0] QHi     = (WW'(1) << (CW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] QLo     = -QHi - WW'(1);
    localparam logic [SQW-1:0]       BestInit = SQW'((64'(1) << SquareBitsMin) - 64'(1));

    // control
    state_t             state_reg, state_next;
    logic [PcBits-1:0]  pc_reg, pc_next;
    region_t            region_reg, region_next;
    logic               second_reg, second_next;
    logic               last_reg, last_next;
    logic [SQW-1:0]     best_sq_reg, best_sq_next;
    logic               best_neg_reg, best_neg_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic               seen_reg, seen_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [RCB-1:0]     rcnt_reg, rcnt_next;

    // datapath
    logic signed [CW-1:0] qry_reg[3], qry_next[3];
    logic signed [CW-1:0] vta_reg[3], vta_next[3];
    logic signed [CW-1:0] vtb_reg[3], vtb_next[3];
    logic signed [CW-1:0] vtc_reg[3], vtc_next[3];
    logic signed [CW-1:0] nrm_reg[3], nrm_next[3];
    logic signed [CW-1:0] cq_reg[3], cq_next[3];
    logic [IW-1:0]        idx_reg, idx_next;
    logic signed [WW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] d_reg[6], d_next[6];
    logic signed [WW-1:0] vc_reg, vc_next, vb_reg, vb_next, va_reg, va_next;
    logic [FracBits:0]    t_reg, t_next, s_reg, s_next;
    logic [SQW-1:0]       sq_reg, sq_next;
    logic                 nd_neg_reg, nd_neg_next;
    logic [RW-1:0]        rx_reg, rx_next, rr_reg, rr_next, rbit_reg, rbit_next;
    logic [DistBits-1:0]  out_dist_reg, out_dist_next;
    logic [IW-1:0]        out_idx_reg, out_idx_next;
    logic                 out_found_reg, out_found_next;

    // edge and offset vectors
    logic signed [VW-1:0] ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    logic signed [VW-1:0] ev[3], fv[3], off[3];
    logic signed [CW-1:0] bv[3];

    uop_t                 uop;
    logic signed [DW-1:0] op_a, op_b;
    logic                 mul_start, mul_done;
    logic signed [WW-1:0] mul_prod;
    logic                 div_start, div_done;
    logic signed [WW-1:0] div_num, div_den;
    logic [FracBits:0]    div_quot;
    logic signed [CW-1:0] blend_base;
    logic signed [WW-1:0] acc_nx;
    logic signed [WW-1:0] qshift;
    logic signed [CW-1:0] qsat;
    logic signed [WW-1:0] w43, w56;
    logic [RW-1:0]        rsum;
    logic [DistBits-1:0]  mag;

    assign uop = uop_at(pc_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab[i]  = VW'(vtb_reg[i]) - VW'(vta_reg[i]);
            ac[i]  = VW'(vtc_reg[i]) - VW'(vta_reg[i]);
            bc[i]  = VW'(vtc_reg[i]) - VW'(vtb_reg[i]);
            ap[i]  = VW'(qry_reg[i]) - VW'(vta_reg[i]);
            bp[i]  = VW'(qry_reg[i]) - VW'(vtb_reg[i]);
            cp[i]  = VW'(qry_reg[i]) - VW'(vtc_reg[i]);
            off[i] = VW'(qry_reg[i]) - VW'(cq_reg[i]);
            // blend base and directions follow the region found
            unique case (region_reg)
                RG_B:    begin bv[i] = vtb_reg[i]; ev[i] = ab[i]; fv[i] = '0;    end
                RG_C:    begin bv[i] = vtc_reg[i]; ev[i] = ab[i]; fv[i] = '0;    end
                RG_AC:   begin bv[i] = vta_reg[i]; ev[i] = ac[i]; fv[i] = '0;    end
                RG_BC:   begin bv[i] = vtb_reg[i]; ev[i] = bc[i]; fv[i] = '0;    end
                RG_IN:   begin bv[i] = vta_reg[i]; ev[i] = ab[i]; fv[i] = ac[i]; end
                default: begin bv[i] = vta_reg[i]; ev[i] = ab[i]; fv[i] = '0;    end
            endcase
        end
    end

    function automatic logic signed [DW-1:0] sel_opnd(opnd_t code);
        logic signed [DW-1:0] r;
        unique case (code)
            O_AB0:  r = DW'(ab[0]);
            O_AB1:  r = DW'(ab[1]);
            O_AB2:  r = DW'(ab[2]);
            O_AC0:  r = DW'(ac[0]);
            O_AC1:  r = DW'(ac[1]);
            O_AC2:  r = DW'(ac[2]);
            O_AP0:  r = DW'(ap[0]);
            O_AP1:  r = DW'(ap[1]);
            O_AP2:  r = DW'(ap[2]);
            O_BP0:  r = DW'(bp[0]);
            O_BP1:  r = DW'(bp[1]);
            O_BP2:  r = DW'(bp[2]);
            O_CP0:  r = DW'(cp[0]);
            O_CP1:  r = DW'(cp[1]);
            O_CP2:  r = DW'(cp[2]);
            O_D1:   r = d_reg[0];
            O_D2:   r = d_reg[1];
            O_D3:   r = d_reg[2];
            O_D4:   r = d_reg[3];
            O_D5:   r = d_reg[4];
            O_D6:   r = d_reg[5];
            O_T:    r = DW'(t_reg);
            O_S:    r = DW'(s_reg);
            O_E0:   r = DW'(ev[0]);
            O_E1:   r = DW'(ev[1]);
            O_E2:   r = DW'(ev[2]);
            O_F0:   r = DW'(fv[0]);
            O_F1:   r = DW'(fv[1]);
            O_F2:   r = DW'(fv[2]);
            O_OFF0: r = DW'(off[0]);
            O_OFF1: r = DW'(off[1]);
            O_OFF2: r = DW'(off[2]);
            O_N0:   r = DW'(nrm_reg[0]);
            O_N1:   r = DW'(nrm_reg[1]);
            O_N2:   r = DW'(nrm_reg[2]);
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        op_a = sel_opnd(uop.a);
        op_b = sel_opnd(uop.b);
    end

    // accumulator update when a product comes back
    always_comb
    begin
        unique case (uop.b)
            O_E1:    blend_base = bv[1];
            O_E2:    blend_base = bv[2];
            default: blend_base = bv[0];
        endcase
        unique case (uop.mode)
            AM_LOAD:  acc_nx = mul_prod;
            AM_ADD:   acc_nx = acc_reg + mul_prod;
            AM_SUB:   acc_nx = acc_reg - mul_prod;
            AM_BLEND: acc_nx = (WW'(blend_base) <<< FracBits) + HalfLsb + mul_prod;
        endcase
        // round half up is floor after the half bias
        qshift = acc_nx >>> FracBits;
        if (qshift < QLo)
        begin
            qsat = QLo[CW-1:0];
        end
        else if (qshift > QHi)
        begin
            qsat = QHi[CW-1:0];
        end
        else
        begin
            qsat = qshift[CW-1:0];
        end
    end

    assign w43  = WW'(d_reg[3]) - WW'(d_reg[2]);
    assign w56  = WW'(d_reg[4]) - WW'(d_reg[5]);
    assign rsum = rr_reg + rbit_reg;
    assign mag  = (rr_reg > RW'(DistMax)) ? DistBits'(DistMax) : rr_reg[DistBits-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        region_next    = region_reg;
        second_next    = second_reg;
        last_next      = last_reg;
        best_sq_next   = best_sq_reg;
        best_neg_next  = best_neg_reg;
        best_idx_next  = best_idx_reg;
        seen_next      = seen_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        rcnt_next      = rcnt_reg;
        qry_next       = qry_reg;
        vta_next       = vta_reg;
        vtb_next       = vtb_reg;
        vtc_next       = vtc_reg;
        nrm_next       = nrm_reg;
        cq_next        = cq_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        vc_next        = vc_reg;
        vb_next        = vb_reg;
        va_next        = va_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        sq_next        = sq_reg;
        nd_neg_next    = nd_neg_reg;
        rx_next        = rx_reg;
        rr_next        = rr_reg;
        rbit_next      = rbit_reg;
        out_dist_next  = out_dist_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        s_tready       = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        div_num        = WW'(d_reg[0]);
        div_den        = WW'(d_reg[0]) - WW'(d_reg[2]);

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        qry_next[i] = s_tdata[0*PW + i*CW +: CW];
                        vta_next[i] = s_tdata[1*PW + i*CW +: CW];
                        vtb_next[i] = s_tdata[2*PW + i*CW +: CW];
                        vtc_next[i] = s_tdata[3*PW + i*CW +: CW];
                        nrm_next[i] = s_tdata[4*PW + i*CW +: CW];
                    end
                    idx_next    = s_tdata[5*PW +: IW];
                    last_next   = s_tlast;
                    region_next = RG_A;
                    pc_next     = '0;
                    // a new query drops the kept best
                    if (s_tuser)
                    begin
                        best_sq_next  = BestInit;
                        best_neg_next = 1'b0;
                        best_idx_next = '0;
                        seen_next     = 1'b0;
                    end
                    state_next = ST_ISSUE;
                end
            end

            ST_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    acc_next = acc_nx;
                    unique case (uop.dest)
                        DS_D1:   d_next[0] = acc_nx[DW-1:0];
                        DS_D2:   d_next[1] = acc_nx[DW-1:0];
                        DS_D3:   d_next[2] = acc_nx[DW-1:0];
                        DS_D4:   d_next[3] = acc_nx[DW-1:0];
                        DS_D5:   d_next[4] = acc_nx[DW-1:0];
                        DS_D6:   d_next[5] = acc_nx[DW-1:0];
                        DS_VC:   vc_next = acc_nx;
                        DS_VB:   vb_next = acc_nx;
                        DS_VA:   va_next = acc_nx;
                        DS_Q0:   cq_next[0] = qsat;
                        DS_Q1:   cq_next[1] = qsat;
                        DS_Q2:   cq_next[2] = qsat;
                        DS_SQ:   sq_next = acc_nx[SQW-1:0];
                        DS_ND:   nd_neg_next = acc_nx[WW-1];
                        default: ;
                    endcase
                    pc_next = pc_reg + 1'b1;
                    if (uop.check)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (pc_reg == PcLast)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end

            ST_CHECK:
            begin
                state_next = ST_ISSUE;
                second_next = 1'b0;
                priority if (pc_reg == PcDotB)
                begin
                    if (d_reg[0] <= 0 && d_reg[1] <= 0)
                    begin
                        region_next = RG_A;
                        t_next      = '0;
                        s_next      = '0;
                        pc_next     = PcBlend;
                    end
                end
                else if (pc_reg == PcDotC)
                begin
                    if (d_reg[2] >= 0 && d_reg[3] <= d_reg[2])
                    begin
                        region_next = RG_B;
                        t_next      = '0;
                        s_next      = '0;
                        pc_next     = PcBlend;
                    end
                end
                else if (pc_reg == PcDetC)
                begin
                    if (d_reg[5] >= 0 && d_reg[4] <= d_reg[5])
                    begin
                        region_next = RG_C;
                        t_next      = '0;
                        s_next      = '0;
                        pc_next     = PcBlend;
                    end
                end
                else if (pc_reg == PcDetB)
                begin
                    if (vc_reg <= 0 && d_reg[0] >= 0 && d_reg[2] <= 0)
                    begin
                        region_next = RG_AB;
                        state_next  = ST_DIVGO;
                    end
                end
                else if (pc_reg == PcDetA)
                begin
                    if (vb_reg <= 0 && d_reg[1] >= 0 && d_reg[5] <= 0)
                    begin
                        region_next = RG_AC;
                        state_next  = ST_DIVGO;
                    end
                end
                else
                begin
                    // last test: edge bc, otherwise the interior
                    if (va_reg <= 0 && w43 >= 0 && w56 >= 0)
                    begin
                        region_next = RG_BC;
                    end
                    else
                    begin
                        region_next = RG_IN;
                    end
                    state_next = ST_DIVGO;
                end
            end

            ST_DIVGO:
            begin
                div_start = 1'b1;
                unique case (region_reg)
                    RG_AC:
                    begin
                        div_num = WW'(d_reg[1]);
                        div_den = WW'(d_reg[1]) - WW'(d_reg[5]);
                    end
                    RG_BC:
                    begin
                        div_num = w43;
                        div_den = w43 + w56;
                    end
                    RG_IN:
                    begin
                        div_num = second_reg ? vc_reg : vb_reg;
                        div_den = va_reg + vb_reg + vc_reg;
                    end
                    default:
                    begin
                        div_num = WW'(d_reg[0]);
                        div_den = WW'(d_reg[0]) - WW'(d_reg[2]);
                    end
                endcase
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (region_reg == RG_IN && !second_reg)
                    begin
                        t_next      = div_quot;
                        second_next = 1'b1;
                        state_next  = ST_DIVGO;
                    end
                    else
                    begin
                        if (region_reg == RG_IN)
                        begin
                            s_next = div_quot;
                        end
                        else
                        begin
                            t_next = div_quot;
                            s_next = '0;
                        end
                        pc_next    = PcBlend;
                        state_next = ST_ISSUE;
                    end
                end
            end

            ST_UPDATE:
            begin
                // strict compare keeps the first of equal distances
                if (sq_reg < best_sq_reg)
                begin
                    best_sq_next  = sq_reg;
                    best_neg_next = nd_neg_reg;
                    best_idx_next = idx_reg;
                end
                seen_next = 1'b1;
                if (last_reg)
                begin
                    rx_next    = RW'(sq_reg < best_sq_reg ? sq_reg : best_sq_reg);
                    rr_next    = '0;
                    rbit_next  = RW'(1) << (RW - 2);
                    rcnt_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ROOT:
            begin
                if (rx_reg >= rsum)
                begin
                    rx_next = rx_reg - rsum;
                    rr_next = (rr_reg >> 1) + rbit_reg;
                end
                else
                begin
                    rr_next = rr_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg == RCB'(RT - 1))
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                if (rx_reg > rr_reg)
                begin
                    rr_next = rr_reg + RW'(1);
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_found_next = seen_reg;
                    out_idx_next   = seen_reg ? best_idx_reg : '0;
                    if (!seen_reg)
                    begin
                        out_dist_next = '0;
                    end
                    else if (best_neg_reg)
                    begin
                        out_dist_next = -mag;
                    end
                    else
                    begin
                        out_dist_next = mag;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            region_reg   <= RG_A;
            second_reg   <= 1'b0;
            last_reg     <= 1'b0;
            best_sq_reg  <= BestInit;
            best_neg_reg <= 1'b0;
            best_idx_reg <= '0;
            seen_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rcnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            region_reg   <= region_next;
            second_reg   <= second_next;
            last_reg     <= last_next;
            best_sq_reg  <= best_sq_next;
            best_neg_reg <= best_neg_next;
            best_idx_reg <= best_idx_next;
            seen_reg     <= seen_next;
            m_tvalid_reg <= m_tvalid_next;
            rcnt_reg     <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qry_reg       <= qry_next;
        vta_reg       <= vta_next;
        vtb_reg       <= vtb_next;
        vtc_reg       <= vtc_next;
        nrm_reg       <= nrm_next;
        cq_reg        <= cq_next;
        idx_reg       <= idx_next;
        acc_reg       <= acc_next;
        d_reg         <= d_next;
        vc_reg        <= vc_next;
        vb_reg        <= vb_next;
        va_reg        <= va_next;
        t_reg         <= t_next;
        s_reg         <= s_next;
        sq_reg        <= sq_next;
        nd_neg_reg    <= nd_neg_next;
        rx_reg        <= rx_next;
        rr_reg        <= rr_next;
        rbit_reg      <= rbit_next;
        out_dist_reg  <= out_dist_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
    end

    sptn_mul #(
        .DW(DW),
        .WW(WW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (op_a),
        .op_b  (op_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    sptn_div #(
        .WW(WW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = ODW'({out_idx_reg, out_dist_reg});

endmodule

`default_nettype wire

// ===== rtl/sptn_checker.sv =====
// port-level checks of the point-triangle distance unit and their bind
`default_nettype none

module sptn_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic m_tuser
);

    // a beat under work blocks the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // every result follows at least one triangle
    a_found_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser)
        else $error("result without any triangle seen");

    // no result straight after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared one cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

endmodule

bind signed_point_triangle_nearest_unit sptn_checker u_sptn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/signed_point_triangle_nearest_unit_tb.sv =====
// testbench of the signed point-to-triangle nearest distance unit
`default_nettype none

module signed_point_triangle_nearest_unit_tb;

    localparam int CoordBits  = 20;
    localparam int IndexBits  = 24;
    localparam int SDataBits  = ((15*CoordBits+IndexBits+7)/8)*8;
    localparam int MDataBits  = ((sptn_pkg::DistBits+IndexBits+7)/8)*8;
    localparam int RandItems  = 1700;
    localparam int StallLimit = 20000;
    localparam int DrainWait  = 800;
    localparam int HoldCycles = 3000;

    typedef struct {
        logic [59:0] query;
        logic [59:0] va;
        logic [59:0] vb;
        logic [59:0] vc;
        logic [59:0] normal;
        logic [23:0] index;
        logic        first;
        logic        last;
    } tri_beat_t;

    typedef struct {
        logic [22:0] sdist;
        logic [23:0] index;
        logic        found;
    } dist_result_t;

    logic clk;
    logic rst_n;
    logic [SDataBits-1:0] s_tdata;
    logic s_tvalid;
    logic s_tready;
    logic s_tuser;
    logic s_tlast;
    logic [MDataBits-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready;
    logic m_tuser;

    tri_beat_t    pending_beats[$];
    dist_result_t expected_dists[$];
    int           errors;
    int           cycle_count;
    int           beats_sent;
    int           idle_cycles;
    int           hold_left;
    bit           hold_done;

    // running best of the current query
    logic [43:0] best_sq;
    logic        best_neg;
    logic [23:0] best_idx;
    logic        seen_tri;

    signed_point_triangle_nearest_unit #(
        .COORD_BITS(CoordBits),
        .INDEX_BITS(IndexBits)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ---------------- predictor ----------------

    function automatic longint coord_of(logic [59:0] w, int slot);
        logic signed [19:0] c;
        c = w[slot*20 +: 20];
        return longint'(c);
    endfunction

    function automatic longint dot3(longint u[3], longint v[3]);
        return u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    endfunction

    function automatic logic signed [127:0] wide(longint x);
        return 128'(signed'(x));
    endfunction

    // Q1.24 ratio num/den clamped to [0,1]
    function automatic longint frac_of(logic signed [127:0] num, logic signed [127:0] den);
        logic signed [127:0] rem;
        longint q;
        q = 0;
        rem = num;
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return longint'(1) << 24;
        for (int i = 0; i < 24; i++)
        begin
            rem = rem <<< 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic void blend(longint base[3], longint e[3], longint t,
                                  longint f[3], longint s, output longint q[3]);
        longint acc;
        longint r;
        for (int i = 0; i < 3; i++)
        begin
            acc = base[i] * (longint'(1) << 24) + t*e[i] + s*f[i] + (longint'(1) << 23);
            r = acc >>> 24;
            if (r < -(longint'(1) << 19))
                r = -(longint'(1) << 19);
            else if (r > (longint'(1) << 19) - 1)
                r = (longint'(1) << 19) - 1;
            q[i] = r;
        end
    endfunction

    // closest point on triangle abc to p by region tests
    function automatic void nearest_on_tri(longint p[3], longint a[3], longint b[3],
                                           longint c[3], output longint q[3]);
        longint ab[3], ac[3], bc[3], ap[3], bp[3], cp[3], nil[3];
        longint d1, d2, d3, d4, d5, d6;
        logic signed [127:0] va, vb, vcw, den;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
            nil[i] = 0;
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        if (d1 <= 0 && d2 <= 0)
        begin
            blend(a, nil, 0, nil, 0, q);
            return;
        end
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        if (d3 >= 0 && d4 <= d3)
        begin
            blend(b, nil, 0, nil, 0, q);
            return;
        end
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        if (d6 >= 0 && d5 <= d6)
        begin
            blend(c, nil, 0, nil, 0, q);
            return;
        end
        vcw = wide(d1)*wide(d4) - wide(d3)*wide(d2);
        if (vcw <= 0 && d1 >= 0 && d3 <= 0)
        begin
            blend(a, ab, frac_of(wide(d1), wide(d1 - d3)), nil, 0, q);
            return;
        end
        vb = wide(d5)*wide(d2) - wide(d1)*wide(d6);
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            blend(a, ac, frac_of(wide(d2), wide(d2 - d6)), nil, 0, q);
            return;
        end
        va = wide(d3)*wide(d6) - wide(d5)*wide(d4);
        if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
        begin
            blend(b, bc, frac_of(wide(d4 - d3), wide((d4 - d3) + (d5 - d6))), nil, 0, q);
            return;
        end
        den = va + vb + vcw;
        blend(a, ab, frac_of(vb, den), ac, frac_of(vcw, den), q);
    endfunction

    // integer square root rounded to nearest
    function automatic longint rounded_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        if (x > r)
            r = r + 1;
        return longint'(r);
    endfunction

    task automatic predict_distance(tri_beat_t t);
        longint p[3], a[3], b[3], c[3], n[3], q[3], off[3];
        longint sq;
        longint mag;
        logic   neg;
        dist_result_t res;
        if (t.first)
        begin
            best_sq  = '1;
            best_neg = 1'b0;
            best_idx = '0;
            seen_tri = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            p[i] = coord_of(t.query, i);
            a[i] = coord_of(t.va, i);
            b[i] = coord_of(t.vb, i);
            c[i] = coord_of(t.vc, i);
            n[i] = coord_of(t.normal, i);
        end
        nearest_on_tri(p, a, b, c, q);
        for (int i = 0; i < 3; i++)
            off[i] = p[i] - q[i];
        sq  = dot3(off, off);
        neg = dot3(n, off) < 0;
        // strictly smaller wins, so ties keep the earlier triangle
        if (sq < longint'(best_sq))
        begin
            best_sq  = 44'(sq);
            best_neg = neg;
            best_idx = t.index;
        end
        seen_tri = 1'b1;
        if (t.last)
        begin
            mag = rounded_root(64'(best_sq));
            if (mag > sptn_pkg::DistMax)
                mag = sptn_pkg::DistMax;
            if (best_neg && mag != 0)
                mag = -mag;
            res.sdist = 23'(mag);
            res.index = best_idx;
            res.found = seen_tri;
            expected_dists = {expected_dists, res};
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [59:0] pt(longint x, longint y, longint z);
        return {20'(z), 20'(y), 20'(x)};
    endfunction

    function automatic logic [59:0] rand_pt(bit wide_range);
        if (wide_range)
            return 60'({$urandom, $urandom});
        return pt(longint'($urandom_range(4000)) - 2000, longint'($urandom_range(4000)) - 2000,
                  longint'($urandom_range(4000)) - 2000);
    endfunction

    task automatic add_beat(logic [59:0] q, logic [59:0] a, logic [59:0] b,
                            logic [59:0] c, logic [59:0] n, logic [23:0] idx,
                            logic first, logic last);
        tri_beat_t t;
        t.query = q; t.va = a; t.vb = b; t.vc = c; t.normal = n;
        t.index = idx; t.first = first; t.last = last;
        pending_beats = {pending_beats, t};
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        tri_beat_t t;
        bit take;
        bit quiet;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            beats_sent <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                beats_sent <= beats_sent + 1;
            // present a new beat when the slot is free or was just taken
            if (!s_tvalid || s_tready)
            begin
                quiet = cycle_count > 100000 && cycle_count < 200000;
                take = pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 21);
                if (take)
                begin
                    t = pending_beats.pop_front();
                    s_tdata  <= SDataBits'({t.index, t.normal, t.vc, t.vb, t.va, t.query});
                    s_tuser  <= t.first;
                    s_tlast  <= t.last;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && beats_sent > 300)
        begin
            // long back-pressure while the sender keeps offering beats
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
            m_tready <= 1'b0;
        else if (cycle_count > 100000 && cycle_count < 200000)
            m_tready <= 1'b1;
        else
            m_tready <= $urandom_range(99) >= 21;
    end

    // ---------------- checker ----------------

    always @(posedge clk)
    begin
        dist_result_t e;
        tri_beat_t t;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                t.query  = s_tdata[59:0];
                t.va     = s_tdata[119:60];
                t.vb     = s_tdata[179:120];
                t.vc     = s_tdata[239:180];
                t.normal = s_tdata[299:240];
                t.index  = s_tdata[323:300];
                t.first  = s_tuser;
                t.last   = s_tlast;
                predict_distance(t);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_dists.size() == 0)
                begin
                    $display("%0t: unexpected beat dist %h index %h found %b", $time,
                             m_tdata[22:0], m_tdata[46:23], m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_dists.pop_front();
                    if (m_tdata[22:0] !== e.sdist || m_tdata[46:23] !== e.index
                        || m_tuser !== e.found)
                    begin
                        $display("%0t: expected dist %h index %h found %b, got %h %h %b",
                                 $time, e.sdist, e.index, e.found,
                                 m_tdata[22:0], m_tdata[46:23], m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        logic [59:0] a, b, c, n;
        int len;
        bit wr;
        errors      = 0;
        cycle_count = 0;
        idle_cycles = 0;
        best_sq     = '1;
        best_neg    = 1'b0;
        best_idx    = '0;
        seen_tri    = 1'b0;
        rst_n       = 1'b0;

        // unit triangle in the z=0 plane, normal +z (1.0 = 1024)
        a = pt(0, 0, 0);
        b = pt(1024, 0, 0);
        c = pt(0, 1024, 0);
        n = pt(0, 0, 1024);
        // vertex regions
        add_beat(pt(-500, -500, 300), a, b, c, n, 24'd1, 1'b1, 1'b1);
        add_beat(pt(2000, -100, -300), a, b, c, n, 24'd2, 1'b1, 1'b1);
        add_beat(pt(-100, 2000, 50), a, b, c, n, 24'd3, 1'b1, 1'b1);
        // edge regions ab, ac, bc
        add_beat(pt(300, -400, 10), a, b, c, n, 24'd4, 1'b1, 1'b1);
        add_beat(pt(-400, 333, -10), a, b, c, n, 24'd5, 1'b1, 1'b1);
        add_beat(pt(900, 900, 77), a, b, c, n, 24'd6, 1'b1, 1'b1);
        // interior, above and behind
        add_beat(pt(200, 300, 500), a, b, c, n, 24'd7, 1'b1, 1'b1);
        add_beat(pt(200, 300, -500), a, b, c, n, 24'd8, 1'b1, 1'b1);
        // point on the triangle: zero offset never negative
        add_beat(pt(100, 100, 0), a, b, c, n, 24'd9, 1'b1, 1'b1);
        // zero normal behind the plane
        add_beat(pt(100, 100, -300), a, b, c, pt(0, 0, 0), 24'hFFFFFF, 1'b1, 1'b1);
        // degenerate triangles: one point, then a segment
        add_beat(pt(5, 6, 7), b, b, b, n, 24'd10, 1'b1, 1'b1);
        add_beat(pt(500, 300, 9), a, b, b, n, 24'd11, 1'b1, 1'b1);
        // extreme coordinates at the ends of the coordinate range
        add_beat(pt(-524288, -524288, -524288), pt(524287, 524287, 524287),
                 pt(524287, 524287, 524287), pt(524287, 524287, 524287),
                 pt(-524288, 524287, -524288), 24'h800000, 1'b1, 1'b1);
        add_beat(pt(524287, -524288, 524287), pt(-524288, 524287, -524288),
                 pt(524287, 524287, -524288), pt(-524288, -524288, 524287),
                 pt(524287, -524288, 524287), 24'h7FFFFF, 1'b1, 1'b1);
        // multi-candidate query with an exact tie that keeps the first, then a closer third candidate
        add_beat(pt(200, 300, 400), a, b, c, n, 24'd20, 1'b1, 1'b0);
        add_beat(pt(200, 300, 400), a, b, c, n, 24'd21, 1'b0, 1'b0);
        add_beat(pt(200, 300, 100), a, b, c, pt(0, 0, -1024), 24'd22, 1'b0, 1'b1);
        // no first: keeps the best after a result
        add_beat(pt(200, 300, 900), a, b, c, n, 24'd23, 1'b0, 1'b1);
        add_beat(pt(200, 300, 50), a, b, c, n, 24'd24, 1'b0, 1'b1);

        // random queries, mostly well-formed groups
        while (pending_beats.size() < RandItems)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                wr = $urandom_range(99) < 20;
                if ($urandom_range(99) < 10)
                    add_beat(rand_pt(wr), rand_pt(wr), rand_pt(wr), rand_pt(wr), rand_pt(1),
                             24'($urandom), 1'($urandom), 1'($urandom));
                else
                    add_beat(rand_pt(wr), rand_pt(wr), rand_pt(wr), rand_pt(wr),
                             $urandom_range(9) == 0 ? 60'd0 : rand_pt(1), 24'($urandom),
                             k == 0, k == len - 1);
            end
        end

        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_dists.size() == 0);
        repeat (DrainWait) @(posedge clk);
        if (errors == 0 && expected_dists.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
